// ===== sv/stws_pkg.sv =====
// package: sizes, codes, beat types and control structs of the sum tree sampler
package stws_pkg;

	localparam int SEGMENTS     = 1024;
	localparam int RATE_ENTRIES = 64;
	localparam int RATE_WIDTH   = 32;

	localparam int LEVELS     = $clog2(SEGMENTS);
	localparam int NODE_W     = LEVELS + 1;
	localparam int TREE_DEPTH = 2 * SEGMENTS;
	localparam int ENTRY_W    = $clog2(RATE_ENTRIES);
	localparam int SUM_W      = RATE_WIDTH + LEVELS;
	localparam int SUM_W1     = SUM_W + 1;

	localparam int SITE_W  = 10;
	localparam int COUNT_W = 16;
	localparam int INDEX_W = 6;
	localparam int VALUE_W = 32;
	localparam int FRAC_W  = 32;
	localparam int TOTAL_W = 42;

	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_SET    = 2'd1,
		REQ_SAMPLE = 2'd2
	} req_type_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_LEAF,
		ST_SET_UP,
		ST_SMP_ROOT,
		ST_SMP_MUL,
		ST_SMP_TGT,
		ST_SMP_DESC
	} state_t;

	typedef enum logic [3:0] {
		OPC_NONE,
		OPC_CLEAR,
		OPC_LATCH,
		OPC_LEAF,
		OPC_SUM,
		OPC_ROOT,
		OPC_MUL_HI,
		OPC_TGT,
		OPC_DESC
	} op_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [SITE_W-1:0]  site;
		logic [COUNT_W-1:0] particle_count;
		logic [INDEX_W-1:0] rate_index;
		logic [VALUE_W-1:0] rate_value;
		logic [FRAC_W-1:0]  uniform;
	} req_t;

	typedef struct packed {
		logic [SITE_W-1:0]  chosen_site;
		logic [TOTAL_W-1:0] total_rate;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [NODE_W-1:0] raddr;
	} tree_ctl_t;

	typedef struct packed {
		logic               we;
		logic [ENTRY_W-1:0] waddr;
		logic [ENTRY_W-1:0] raddr;
	} rate_ctl_t;

	typedef struct packed {
		logic              finish;
		logic [SITE_W-1:0] chosen_site;
	} done_t;

endpackage

// ===== sv/stws_ram.sv =====
// generic single write port ram with registered read
module stws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/stws_dp.sv =====
// shared datapath: one adder-subtractor and one 32x32 multiplier with operand registers
module stws_dp (
	input  logic                                clk,
	input  stws_pkg::op_t                       op,
	input  logic [stws_pkg::FRAC_W-1:0]         uniform,
	input  logic [stws_pkg::RATE_WIDTH-1:0]     rate_rdata,
	input  logic [stws_pkg::SUM_W-1:0]          tree_rdata,
	output logic [stws_pkg::SUM_W-1:0]          tree_wdata,
	output logic                                go_right,
	output logic [stws_pkg::SUM_W-1:0]          total
);

	logic [stws_pkg::FRAC_W-1:0] u_q;
	logic [stws_pkg::SUM_W-1:0]  acc_q;
	logic [stws_pkg::SUM_W-1:0]  total_q;
	logic [stws_pkg::PROD_W-1:0] prod_q;

	logic                        add_sub;
	logic [stws_pkg::SUM_W-1:0]  add_b;
	logic [stws_pkg::SUM_W-1:0]  add_res;
	logic                        carry;
	logic [stws_pkg::MUL_W-1:0]  mul_a;
	logic [stws_pkg::PROD_W-1:0] mul_p;

	always_comb begin
		add_sub = (op == stws_pkg::OPC_DESC);
		add_b   = (op == stws_pkg::OPC_TGT) ? stws_pkg::SUM_W'(prod_q) : tree_rdata;
		{carry, add_res} = {1'b0, acc_q}
			+ {1'b0, (add_sub ? ~add_b : add_b)}
			+ stws_pkg::SUM_W1'(add_sub);
		// left sum strictly below target: no borrow and nonzero difference
		go_right = add_sub && carry && (add_res != '0);
		mul_a    = (op == stws_pkg::OPC_MUL_HI) ?
			stws_pkg::MUL_W'(total_q >> stws_pkg::MUL_W) : stws_pkg::MUL_W'(tree_rdata);
		mul_p    = stws_pkg::PROD_W'(mul_a) * stws_pkg::PROD_W'(u_q);
		case (op)
			stws_pkg::OPC_CLEAR: tree_wdata = '0;
			stws_pkg::OPC_LEAF:  tree_wdata = stws_pkg::SUM_W'(rate_rdata);
			default:             tree_wdata = add_res;
		endcase
	end

	always_ff @(posedge clk) begin
		case (op)
			stws_pkg::OPC_LATCH: begin
				u_q <= uniform;
			end
			stws_pkg::OPC_LEAF: begin
				acc_q <= stws_pkg::SUM_W'(rate_rdata);
			end
			stws_pkg::OPC_SUM: begin
				acc_q <= add_res;
			end
			stws_pkg::OPC_ROOT: begin
				total_q <= tree_rdata;
				prod_q  <= mul_p;
			end
			stws_pkg::OPC_MUL_HI: begin
				prod_q <= mul_p;
				acc_q  <= stws_pkg::SUM_W'(prod_q[stws_pkg::PROD_W-1:stws_pkg::MUL_W]);
			end
			stws_pkg::OPC_TGT: begin
				acc_q <= add_res;
			end
			stws_pkg::OPC_DESC: begin
				if (go_right) begin
					acc_q <= add_res;
				end
			end
			default: begin
			end
		endcase
	end

	assign total = total_q;

endmodule

// ===== sv/stws_seq.sv =====
// sequencer: state machine, node counter and memory addressing
module stws_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  stws_pkg::req_t        req,
	input  logic                  go_right,
	output logic                  busy,
	output stws_pkg::op_t         op,
	output stws_pkg::tree_ctl_t   tree_ctl,
	output stws_pkg::rate_ctl_t   rate_ctl,
	output stws_pkg::done_t       done
);

	stws_pkg::state_t state_q, state_d;
	logic [stws_pkg::NODE_W-1:0] node_q, node_d;

	logic [stws_pkg::NODE_W-1:0] leaf;
	logic [stws_pkg::NODE_W-1:0] parent;
	logic [stws_pkg::NODE_W-1:0] child;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stws_pkg::ST_CLEAR;
			node_q  <= '0;
		end else begin
			state_q <= state_d;
			node_q  <= node_d;
		end
	end

	always_comb begin
		leaf   = stws_pkg::NODE_W'(stws_pkg::SEGMENTS)
			| (stws_pkg::NODE_W'(req.site) & stws_pkg::NODE_W'(stws_pkg::SEGMENTS - 1));
		parent = node_q >> 1;
		child  = {node_q[stws_pkg::NODE_W-2:0], go_right};

		state_d        = state_q;
		node_d         = node_q;
		op             = stws_pkg::OPC_NONE;
		tree_ctl.we    = 1'b0;
		tree_ctl.waddr = node_q;
		tree_ctl.raddr = node_q ^ stws_pkg::NODE_W'(1);
		rate_ctl.we    = 1'b0;
		rate_ctl.waddr = stws_pkg::ENTRY_W'(req.rate_index);
		// counts past the table saturate to the last entry
		rate_ctl.raddr = (32'(req.particle_count) >= stws_pkg::RATE_ENTRIES) ?
			stws_pkg::ENTRY_W'(stws_pkg::RATE_ENTRIES - 1) :
			stws_pkg::ENTRY_W'(req.particle_count);
		done.finish      = 1'b0;
		done.chosen_site = stws_pkg::SITE_W'(child[stws_pkg::LEVELS-1:0]);

		case (state_q)
			stws_pkg::ST_CLEAR: begin
				op          = stws_pkg::OPC_CLEAR;
				tree_ctl.we = 1'b1;
				node_d      = node_q + stws_pkg::NODE_W'(1);
				if (node_q == '1) begin
					state_d = stws_pkg::ST_IDLE;
				end
			end
			stws_pkg::ST_IDLE: begin
				if (start) begin
					case (req.req_type)
						stws_pkg::REQ_LOAD: begin
							rate_ctl.we = (32'(req.rate_index) < stws_pkg::RATE_ENTRIES);
						end
						stws_pkg::REQ_SET: begin
							node_d  = leaf;
							state_d = stws_pkg::ST_SET_LEAF;
						end
						stws_pkg::REQ_SAMPLE: begin
							op             = stws_pkg::OPC_LATCH;
							tree_ctl.raddr = stws_pkg::NODE_W'(1);
							state_d        = stws_pkg::ST_SMP_ROOT;
						end
						default: begin
						end
					endcase
				end
			end
			stws_pkg::ST_SET_LEAF: begin
				op          = stws_pkg::OPC_LEAF;
				tree_ctl.we = 1'b1;
				state_d     = stws_pkg::ST_SET_UP;
			end
			stws_pkg::ST_SET_UP: begin
				op             = stws_pkg::OPC_SUM;
				tree_ctl.we    = 1'b1;
				tree_ctl.waddr = parent;
				tree_ctl.raddr = parent ^ stws_pkg::NODE_W'(1);
				node_d         = parent;
				if (parent == stws_pkg::NODE_W'(1)) begin
					state_d = stws_pkg::ST_IDLE;
				end
			end
			stws_pkg::ST_SMP_ROOT: begin
				op      = stws_pkg::OPC_ROOT;
				state_d = stws_pkg::ST_SMP_MUL;
			end
			stws_pkg::ST_SMP_MUL: begin
				op      = stws_pkg::OPC_MUL_HI;
				state_d = stws_pkg::ST_SMP_TGT;
			end
			stws_pkg::ST_SMP_TGT: begin
				op             = stws_pkg::OPC_TGT;
				node_d         = stws_pkg::NODE_W'(1);
				tree_ctl.raddr = stws_pkg::NODE_W'(2);
				state_d        = stws_pkg::ST_SMP_DESC;
			end
			stws_pkg::ST_SMP_DESC: begin
				op             = stws_pkg::OPC_DESC;
				node_d         = child;
				tree_ctl.raddr = child << 1;
				if (child[stws_pkg::NODE_W-1]) begin
					done.finish = 1'b1;
					state_d     = stws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stws_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != stws_pkg::ST_IDLE);

endmodule

// ===== sv/sum_tree_weighted_sampler_top.sv =====
// top level: weighted sampler over a sum tree with rate lookup table
//
//  channel   signals              direction  transfer
//  request   start, busy, req     in         beat taken when start is high and busy low
//  result    rsp_valid, rsp       out        one-cycle strobe, always taken
//
// load: no result, busy stays low. set: leaf write then one ancestor sum per
// level through the shared adder and the tree ram's one write port.
// sample: root read, two passes through the shared multiplier, target add,
// then one left-child read and compare per level, then the result strobe.
// after reset the tree ram is cleared one node a cycle, all 2048 nodes, with busy high.
// the receiver cannot stall; busy drops in the cycle the result is shown.
module sum_tree_weighted_sampler_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  stws_pkg::req_t req,
	output logic           rsp_valid,
	output stws_pkg::rsp_t rsp
);

	stws_pkg::op_t       op;
	stws_pkg::tree_ctl_t tree_ctl;
	stws_pkg::rate_ctl_t rate_ctl;
	stws_pkg::done_t     done;
	logic                go_right;

	logic [stws_pkg::RATE_WIDTH-1:0] rate_rdata;
	logic [stws_pkg::SUM_W-1:0]      tree_rdata;
	logic [stws_pkg::SUM_W-1:0]      tree_wdata;
	logic [stws_pkg::SUM_W-1:0]      total;

	logic           rsp_valid_q;
	stws_pkg::rsp_t rsp_q;

	stws_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.go_right (go_right),
		.busy     (busy),
		.op       (op),
		.tree_ctl (tree_ctl),
		.rate_ctl (rate_ctl),
		.done     (done)
	);

	stws_dp u_dp (
		.clk        (clk),
		.op         (op),
		.uniform    (req.uniform),
		.rate_rdata (rate_rdata),
		.tree_rdata (tree_rdata),
		.tree_wdata (tree_wdata),
		.go_right   (go_right),
		.total      (total)
	);

	stws_ram #(
		.WIDTH (stws_pkg::RATE_WIDTH),
		.DEPTH (stws_pkg::RATE_ENTRIES)
	) u_rate_ram (
		.clk   (clk),
		.we    (rate_ctl.we),
		.waddr (rate_ctl.waddr),
		.wdata (stws_pkg::RATE_WIDTH'(req.rate_value)),
		.raddr (rate_ctl.raddr),
		.rdata (rate_rdata)
	);

	stws_ram #(
		.WIDTH (stws_pkg::SUM_W),
		.DEPTH (stws_pkg::TREE_DEPTH)
	) u_tree_ram (
		.clk   (clk),
		.we    (tree_ctl.we),
		.waddr (tree_ctl.waddr),
		.wdata (tree_wdata),
		.raddr (tree_ctl.raddr),
		.rdata (tree_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= done.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (done.finish) begin
			rsp_q.chosen_site <= done.chosen_site;
			rsp_q.total_rate  <= stws_pkg::TOTAL_W'(total);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
